FILE: rtl/nupd_pkg.sv
// ----------------------------------------------------------------------------
// nupd_pkg
// Shared types and constants of the blood-pressure module frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nupd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_START_BYTE    = 2'd0;
  localparam logic [1:0] CFG_END_TEXT_BYTE = 2'd1;
  localparam logic [1:0] CFG_RETURN_BYTE   = 2'd2;

  localparam logic [7:0] START_BYTE_RST    = 8'd2;
  localparam logic [7:0] END_TEXT_BYTE_RST = 8'd3;
  localparam logic [7:0] RETURN_BYTE_RST   = 8'd13;

  // frame lengths and marker characters
  localparam logic [5:0] LEN_SHORT = 6'd6;
  localparam logic [5:0] LEN_PRESS = 6'd10;
  localparam logic [5:0] LEN_LONG  = 6'd42;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_TWO  = 8'h32;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_S    = 8'h53;

  // captured byte slots
  localparam int NUM_SLOTS = 17;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam logic [SLOT_W-1:0] SLOT_B1  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_B2  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_B3  = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_B12 = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_B13 = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_B16 = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_B19 = SLOT_W'(8);
  localparam logic [SLOT_W-1:0] SLOT_B22 = SLOT_W'(11);
  localparam logic [SLOT_W-1:0] SLOT_B27 = SLOT_W'(14);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int KIND_W = 3;
  localparam int DATA_W = 88;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESSURE   = 3'd0,
    KIND_DONE       = 3'd1,
    KIND_END_OTHER  = 3'd2,
    KIND_RESULT_OK  = 3'd3,
    KIND_RESULT_ERR = 3'd4,
    KIND_BAD_FRAME  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_HARDWARE     = 4'd1,
    ERR_CUFF         = 4'd2,
    ERR_LEAK         = 4'd3,
    ERR_PRESSURE     = 4'd4,
    ERR_WEAK         = 4'd5,
    ERR_RANGE        = 4'd6,
    ERR_MOTION       = 4'd7,
    ERR_OVERPRESSURE = 4'd8,
    ERR_SATURATION   = 4'd9,
    ERR_TIMEOUT      = 4'd10,
    ERR_CUFF_TYPE    = 4'd11
  } err_class_e;

  typedef enum logic [1:0] {
    FLEN_SHORT = 2'd0,
    FLEN_PRESS = 2'd1,
    FLEN_LONG  = 2'd2
  } flen_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_text_byte;
    logic [7:0] return_byte;
  } cfg_t;

  typedef struct packed {
    flen_e                       flen;
    logic                        trailer_ok;
    logic [NUM_SLOTS-1:0][7:0]   cap;
  } frame_rec_t;

endpackage

`default_nettype wire

FILE: rtl/nibp_uart_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// nibp_uart_packet_decoder_unit
// Decoder of the framed byte stream sent by a blood-pressure module.
// ----------------------------------------------------------------------------
// Bytes received from the serial link enter on the s_ stream, one byte per
// beat. Outside a frame every byte but the start byte is dropped. A complete
// frame gives one result beat on the m_ stream: the kind in m_tuser and the
// decoded values in m_tdata. Other frames give nothing until they end.
// The cfg_ channel writes the start, end-of-text and return byte registers;
// cfg_ready is always high; writes are to be made while the block is idle,
// which the block does not enforce. Throughput is one byte per cycle while
// s_tready is high. The front keeps taking bytes while results wait, through
// a two-entry frame queue and the output register. The last frame byte queues
// its record; the back loads the result into the output register and raises
// m_tvalid. s_tready drops only when two frames wait in the queue behind a
// stalled result, i.e. when m_tready stays low while two further frames
// arrive. Reset clears the hunting state, the queue and the output valid,
// and loads the registers with 2, 3 and 13; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nibp_uart_packet_decoder_unit import nupd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // rx_byte
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // cuff_pressure, systolic, diastolic, mean_pressure, pulse_rate, error_class
  output logic [DATA_W-1:0]      m_tdata,
  output logic [KIND_W-1:0]      m_tuser,   // packet_kind
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data
);

  cfg_t       cfg;
  logic       push_valid;
  logic       push_ready;
  frame_rec_t push_rec;
  logic       pop_valid;
  logic       pop_ready;
  frame_rec_t pop_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= START_BYTE_RST;
      cfg.end_text_byte <= END_TEXT_BYTE_RST;
      cfg.return_byte   <= RETURN_BYTE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_BYTE:    cfg.start_byte    <= cfg_data;
        CFG_END_TEXT_BYTE: cfg.end_text_byte <= cfg_data;
        CFG_RETURN_BYTE:   cfg.return_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  nupd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .rx_byte    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  nupd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  nupd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/nupd_front.sv
// ----------------------------------------------------------------------------
// nupd_front
// Frame hunter: finds the start byte, counts the frame, captures the bytes
// the decoder needs and checks the trailer, then queues one frame record.
// ----------------------------------------------------------------------------
`default_nettype none

module nupd_front import nupd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            push_valid,
  input  wire logic       push_ready,
  output frame_rec_t      push_rec
);

  logic                      in_frame;
  logic [5:0]                byte_count;
  logic [5:0]                frame_length;
  logic [7:0]                prev_byte;
  logic [NUM_SLOTS-1:0][7:0] cap;

  logic              accept;
  logic [5:0]        count_inc;
  logic              frame_end;
  logic              slot_hit;
  logic [SLOT_W-1:0] slot_idx;

  assign in_ready   = push_ready;
  assign accept     = in_valid && push_ready;
  assign count_inc  = byte_count + 6'd1;
  assign frame_end  = in_frame && (count_inc == frame_length);
  assign push_valid = in_valid && frame_end;

  always_comb begin
    push_rec.cap        = cap;
    push_rec.trailer_ok = (prev_byte == cfg.end_text_byte) && (rx_byte == cfg.return_byte);
    if (frame_length == LEN_SHORT) begin
      push_rec.flen = FLEN_SHORT;
    end else if (frame_length == LEN_PRESS) begin
      push_rec.flen = FLEN_PRESS;
    end else begin
      push_rec.flen = FLEN_LONG;
    end
  end

  // byte position to capture slot
  always_comb begin
    slot_hit = 1'b1;
    slot_idx = '0;
    case (byte_count) inside
      [6'd1:6'd3]:   slot_idx = SLOT_B1 + SLOT_W'(byte_count - 6'd1);
      [6'd12:6'd13]: slot_idx = SLOT_B12 + SLOT_W'(byte_count - 6'd12);
      [6'd16:6'd24]: slot_idx = SLOT_B16 + SLOT_W'(byte_count - 6'd16);
      [6'd27:6'd29]: slot_idx = SLOT_B27 + SLOT_W'(byte_count - 6'd27);
      default:       slot_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      byte_count   <= '0;
      frame_length <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx_byte == cfg.start_byte) begin
          in_frame     <= 1'b1;
          byte_count   <= 6'd1;
          frame_length <= '0;
        end
      end else begin
        if (byte_count == 6'd1) begin
          if (rx_byte == CHAR_NINE) begin
            frame_length <= LEN_SHORT;
          end else if (rx_byte == CHAR_S) begin
            frame_length <= LEN_LONG;
          end else begin
            frame_length <= LEN_PRESS;
          end
        end
        if (frame_end) begin
          in_frame   <= 1'b0;
          byte_count <= '0;
        end else begin
          byte_count <= count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame) begin
      prev_byte <= rx_byte;
      if (slot_hit) begin
        cap[slot_idx] <= rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nupd_queue.sv
// ----------------------------------------------------------------------------
// nupd_queue
// Short first-in first-out queue of frame records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module nupd_queue import nupd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_valid,
  output logic            push_ready,
  input  wire frame_rec_t push_rec,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output frame_rec_t      pop_rec
);

  frame_rec_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_rec    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nupd_back.sv
// ----------------------------------------------------------------------------
// nupd_back
// Frame decoder: turns a queued frame record into one result beat held in
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nupd_back import nupd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire frame_rec_t        pop_rec,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [DATA_W-1:0]      m_tdata,
  output logic [KIND_W-1:0]      m_tuser
);

  localparam logic [15:0] BIAS3 = 16'(CHAR_ZERO) * 16'd111;
  localparam logic [15:0] BIAS2 = 16'(CHAR_ZERO) * 16'd11;

  function automatic logic [15:0] three_digits(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
    return 16'(a) * 16'd100 + 16'(b) * 16'd10 + 16'(c) - BIAS3;
  endfunction

  function automatic err_class_e map_error(input logic [15:0] code);
    err_class_e res;
    res = ERR_NONE;
    case (code)
      16'd1:   res = ERR_HARDWARE;
      16'd6:   res = ERR_CUFF;
      16'd7:   res = ERR_LEAK;
      16'd8:   res = ERR_PRESSURE;
      16'd9:   res = ERR_WEAK;
      16'd10:  res = ERR_RANGE;
      16'd11:  res = ERR_MOTION;
      16'd12:  res = ERR_OVERPRESSURE;
      16'd13:  res = ERR_SATURATION;
      16'd19:  res = ERR_TIMEOUT;
      16'd20:  res = ERR_CUFF_TYPE;
      default: res = ERR_NONE;
    endcase
    return res;
  endfunction

  kind_e       d_kind;
  logic [15:0] d_cuff;
  logic [15:0] d_sys;
  logic [15:0] d_dia;
  logic [15:0] d_mean;
  logic [15:0] d_pulse;
  err_class_e  d_err;
  logic [15:0] err_code;
  logic        load;

  assign pop_ready = !m_tvalid || m_tready;
  assign load      = pop_valid && pop_ready;
  assign err_code  = 16'(pop_rec.cap[SLOT_B12]) * 16'd10 + 16'(pop_rec.cap[SLOT_B13]) - BIAS2;

  always_comb begin
    d_kind  = KIND_BAD_FRAME;
    d_cuff  = '0;
    d_sys   = '0;
    d_dia   = '0;
    d_mean  = '0;
    d_pulse = '0;
    d_err   = ERR_NONE;
    if (pop_rec.trailer_ok) begin
      unique case (pop_rec.flen)
        FLEN_PRESS: begin
          d_kind = KIND_PRESSURE;
          d_cuff = three_digits(pop_rec.cap[SLOT_B1], pop_rec.cap[SLOT_B2],
                                pop_rec.cap[SLOT_B3]);
        end
        FLEN_SHORT: begin
          if (pop_rec.cap[SLOT_B1] == CHAR_NINE && pop_rec.cap[SLOT_B2] == CHAR_NINE &&
              pop_rec.cap[SLOT_B3] == CHAR_NINE) begin
            d_kind = KIND_DONE;
          end else begin
            d_kind = KIND_END_OTHER;
          end
        end
        FLEN_LONG: begin
          if (pop_rec.cap[SLOT_B2] == CHAR_TWO) begin
            d_kind = KIND_RESULT_ERR;
            d_err  = map_error(err_code);
          end else begin
            d_kind  = KIND_RESULT_OK;
            d_sys   = three_digits(pop_rec.cap[SLOT_B16], pop_rec.cap[SLOT_B16 + SLOT_W'(1)],
                                   pop_rec.cap[SLOT_B16 + SLOT_W'(2)]);
            d_dia   = three_digits(pop_rec.cap[SLOT_B19], pop_rec.cap[SLOT_B19 + SLOT_W'(1)],
                                   pop_rec.cap[SLOT_B19 + SLOT_W'(2)]);
            d_mean  = three_digits(pop_rec.cap[SLOT_B22], pop_rec.cap[SLOT_B22 + SLOT_W'(1)],
                                   pop_rec.cap[SLOT_B22 + SLOT_W'(2)]);
            d_pulse = three_digits(pop_rec.cap[SLOT_B27], pop_rec.cap[SLOT_B27 + SLOT_W'(1)],
                                   pop_rec.cap[SLOT_B27 + SLOT_W'(2)]);
          end
        end
        default: d_kind = KIND_BAD_FRAME;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= d_kind;
      m_tdata <= {4'b0000, d_err, d_pulse, d_mean, d_dia, d_sys, d_cuff};
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the blood-pressure module frame decoder.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes comes first: noise while hunting, a
// pressure frame with the largest digit values and a start byte inside it, a
// measure-done frame and a frame with a swapped trailer. After that, random
// frames of all three lengths run under several register settings. Most are
// well formed with random content and error codes. Some are cut short, have a
// bad trailer or are mixed with noise. Each accepted byte goes through a local
// frame decoder, and the decoded results are checked against the m_ stream in
// order. Both streams idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import nupd_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_BYTES = 270;
  localparam int NUM_PHASES  = 5;

  typedef struct packed {
    kind_e             kind;
    logic signed [15:0] cuff;
    logic signed [15:0] sys;
    logic signed [15:0] dia;
    logic signed [15:0] mean;
    logic signed [15:0] pulse;
    err_class_e        err;
  } result_t;

  typedef struct {
    logic [7:0] rx;
    bit         has_res;
    result_t    res;
  } dir_row_t;

  localparam result_t NO_RES = '{KIND_PRESSURE, 0, 0, 0, 0, 0, ERR_NONE};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'd0;    // rx_byte
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // cuff_pressure, systolic, diastolic, mean_pressure, pulse_rate, error_class
  logic [DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0] m_tuser;           // packet_kind
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_START_BYTE;
  logic [7:0]        cfg_data = 8'd0;

  nibp_uart_packet_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state mirrored on the bench side
  cfg_t       regs = '{START_BYTE_RST, END_TEXT_BYTE_RST, RETURN_BYTE_RST};
  bit         in_frame = 1'b0;
  logic [5:0] byte_cnt = 6'd0;
  logic [5:0] frame_len = 6'd0;
  logic [7:0] frame_mem [64];

  result_t decoded_q [$];
  int      n_bytes = 0;
  int      n_results = 0;
  int      n_errors = 0;
  int      kind_seen [6] = '{0, 0, 0, 0, 0, 0};
  int      quiet = 0;
  int      hold_left = 0;
  bit      idle_on = 1'b1;
  int      err_codes [11] = '{1, 6, 7, 8, 9, 10, 11, 12, 13, 19, 20};

  dir_row_t dir_rows [24] = '{
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    // pressure frame, every digit byte at its top value, start byte as data
    '{8'h02, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'h30, 1'b0, NO_RES},
    '{8'h30, 1'b0, NO_RES},
    '{8'h30, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h0D, 1'b1, '{KIND_PRESSURE, 22977, 0, 0, 0, 0, ERR_NONE}},
    // measure done
    '{8'h02, 1'b0, NO_RES},
    '{8'h39, 1'b0, NO_RES},
    '{8'h39, 1'b0, NO_RES},
    '{8'h39, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h0D, 1'b1, '{KIND_DONE, 0, 0, 0, 0, 0, ERR_NONE}},
    // trailer bytes swapped
    '{8'h02, 1'b0, NO_RES},
    '{8'h39, 1'b0, NO_RES},
    '{8'h39, 1'b0, NO_RES},
    '{8'h39, 1'b0, NO_RES},
    '{8'h0D, 1'b0, NO_RES},
    '{8'h03, 1'b1, '{KIND_BAD_FRAME, 0, 0, 0, 0, 0, ERR_NONE}}
  };

  function automatic logic signed [15:0] digits3(int i);
    int v;
    v = (int'(frame_mem[i]) - int'(CHAR_ZERO)) * 100
      + (int'(frame_mem[i + 1]) - int'(CHAR_ZERO)) * 10
      + (int'(frame_mem[i + 2]) - int'(CHAR_ZERO));
    return v[15:0];
  endfunction

  function automatic void decode_byte(input logic [7:0] b, output bit got,
                                      output result_t r);
    int code;
    got = 1'b0;
    r = NO_RES;
    if (!in_frame) begin
      if (b == regs.start_byte) begin
        frame_mem[0] = b;
        byte_cnt = 6'd1;
        frame_len = 6'd0;
        in_frame = 1'b1;
      end
    end else begin
      frame_mem[byte_cnt] = b;
      if (byte_cnt == 6'd1) begin
        if (b == CHAR_NINE) frame_len = LEN_SHORT;
        else if (b == CHAR_S) frame_len = LEN_LONG;
        else frame_len = LEN_PRESS;
      end
      byte_cnt = byte_cnt + 6'd1;
      if (byte_cnt == frame_len) begin
        got = 1'b1;
        in_frame = 1'b0;
        byte_cnt = 6'd0;
        if (frame_mem[frame_len - 6'd2] != regs.end_text_byte ||
            frame_mem[frame_len - 6'd1] != regs.return_byte) begin
          r.kind = KIND_BAD_FRAME;
        end else if (frame_len == LEN_PRESS) begin
          r.kind = KIND_PRESSURE;
          r.cuff = digits3(1);
        end else if (frame_len == LEN_SHORT) begin
          r.kind = (frame_mem[1] == CHAR_NINE && frame_mem[2] == CHAR_NINE &&
                    frame_mem[3] == CHAR_NINE) ? KIND_DONE : KIND_END_OTHER;
        end else if (frame_mem[2] == CHAR_TWO) begin
          r.kind = KIND_RESULT_ERR;
          code = (int'(frame_mem[12]) - int'(CHAR_ZERO)) * 10
               + (int'(frame_mem[13]) - int'(CHAR_ZERO));
          case (code)
            1:       r.err = ERR_HARDWARE;
            6:       r.err = ERR_CUFF;
            7:       r.err = ERR_LEAK;
            8:       r.err = ERR_PRESSURE;
            9:       r.err = ERR_WEAK;
            10:      r.err = ERR_RANGE;
            11:      r.err = ERR_MOTION;
            12:      r.err = ERR_OVERPRESSURE;
            13:      r.err = ERR_SATURATION;
            19:      r.err = ERR_TIMEOUT;
            20:      r.err = ERR_CUFF_TYPE;
            default: r.err = ERR_NONE;
          endcase
        end else begin
          r.kind = KIND_RESULT_OK;
          r.sys = digits3(16);
          r.dia = digits3(19);
          r.mean = digits3(22);
          r.pulse = digits3(27);
        end
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit has_typed,
                           input result_t typed);
    bit      got;
    result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    n_bytes++;
    decode_byte(b, got, r);
    if (has_typed) decoded_q.push_back(typed);
    else if (got) decoded_q.push_back(r);
  endtask

  // leaves cfg_valid high, the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_BYTE:    regs.start_byte = val;
      CFG_END_TEXT_BYTE: regs.end_text_byte = val;
      CFG_RETURN_BYTE:   regs.return_byte = val;
      default: ;
    endcase
  endtask

  task automatic send_frame();
    logic [7:0] fr [42];
    int len;
    int n_send;
    int code;
    int i;
    repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
      send_byte(8'($urandom), 1'b0, NO_RES);
    fr[0] = regs.start_byte;
    case ($urandom_range(0, 2))
      0: begin
        len = 10;
        do begin
          fr[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                              : CHAR_ZERO + 8'($urandom_range(0, 8));
        end while (fr[1] == CHAR_NINE || fr[1] == CHAR_S);
      end
      1: begin
        len = 6;
        fr[1] = CHAR_NINE;
      end
      default: begin
        len = 42;
        fr[1] = CHAR_S;
      end
    endcase
    for (i = 2; i < len - 2; i++)
      fr[i] = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                          : CHAR_ZERO + 8'($urandom_range(0, 9));
    if (len == 6 && $urandom_range(0, 1) == 0) begin
      fr[2] = CHAR_NINE;
      fr[3] = CHAR_NINE;
    end
    if (len == 42 && $urandom_range(0, 2) == 0) begin
      fr[2] = CHAR_TWO;
      code = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99)
                                         : err_codes[$urandom_range(0, 10)];
      fr[12] = CHAR_ZERO + 8'(code / 10);
      fr[13] = CHAR_ZERO + 8'(code % 10);
    end
    if ($urandom_range(0, 9) == 0) fr[$urandom_range(2, len - 3)] = regs.start_byte;
    fr[len - 2] = regs.end_text_byte;
    fr[len - 1] = regs.return_byte;
    if ($urandom_range(0, 7) == 0)
      fr[len - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    n_send = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len - 1) : len;
    for (i = 0; i < n_send; i++) send_byte(fr[i], 1'b0, NO_RES);
  endtask

  task automatic note_fail(input string what, input result_t e, input result_t a);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%s (expected/actual): kind %0d/%0d cuff %0d/%0d sys %0d/%0d dia %0d/%0d",
               what, e.kind, a.kind, e.cuff, a.cuff, e.sys, a.sys, e.dia, a.dia);
      $display("  mean %0d/%0d pulse %0d/%0d err %0d/%0d",
               e.mean, a.mean, e.pulse, a.pulse, e.err, a.err);
    end
  endtask

  // result beats
  always @(posedge clk) begin : result_mon
    result_t act;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      act = '{kind_e'(m_tuser), m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
              m_tdata[63:48], m_tdata[79:64], err_class_e'(m_tdata[83:80])};
      n_results++;
      if (int'(act.kind) < 6) kind_seen[int'(act.kind)]++;
      if (decoded_q.size() == 0) begin
        note_fail("unexpected result", NO_RES, act);
      end else begin
        want = decoded_q.pop_front();
        if (act.kind !== want.kind || act.cuff !== want.cuff || act.sys !== want.sys ||
            act.dia !== want.dia || act.mean !== want.mean || act.pulse !== want.pulse ||
            act.err !== want.err)
          note_fail("result mismatch", want, act);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      hold_left <= $urandom_range(1, 6) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // longest quiet stretch of a correct run is a sender gap plus a receiver
  // stall plus the settle pause
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin : stim
    int p;
    int i;
    int target;
    cfg_t next_regs;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < 24; i++)
      send_byte(dir_rows[i].rx, dir_rows[i].has_res, dir_rows[i].res);
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        case (p)
          1:       next_regs = '{8'hFF, 8'h00, 8'hFF};
          2:       next_regs = '{8'h00, 8'hFF, 8'h00};
          3:       next_regs = '{8'($urandom), 8'($urandom), 8'($urandom)};
          default: next_regs = '{START_BYTE_RST, END_TEXT_BYTE_RST, RETURN_BYTE_RST};
        endcase
        write_reg(CFG_START_BYTE, next_regs.start_byte);
        write_reg(CFG_END_TEXT_BYTE, next_regs.end_text_byte);
        write_reg(CFG_RETURN_BYTE, next_regs.return_byte);
        cfg_valid <= 1'b0;
      end
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      target = n_bytes + PHASE_BYTES;
      while (n_bytes < target) send_frame();
      // close any open frame so the next register write lands while hunting
      while (in_frame) send_byte(regs.return_byte, 1'b0, NO_RES);
    end
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d bytes over %0d register settings gave %0d results", n_bytes,
             NUM_PHASES, n_results);
    $display("pressure %0d, done %0d, end other %0d, ok %0d, error %0d, bad frame %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (n_errors == 0 && decoded_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
